[src/bda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the binary to decimal ASCII unit.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int VALUE_W   = 64;
    localparam int BIT_CNT_W = 7;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         width_code;
        logic               is_signed;
    } num_item_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } chr_item_t;

    // Commands from the sequencer to the shift datapath
    typedef struct packed {
        logic load;
        logic shift_bit;
        logic shift_digit;
    } bda_ctrl_t;

endpackage

[src/bda_dabble.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_dabble
// Shift-and-add-3 datapath: shifts the binary magnitude into a BCD register
// one bit per cycle of shift_bit, then shifts the BCD register out one digit per cycle of shift_digit.
// ----------------------------------------------------------------------------
module bda_dabble
    import bda_pkg::*;
#(
    parameter int MAX_DIGITS = 20
)
(
    input  logic               clk,
    input  bda_ctrl_t          ctrl,
    input  logic [VALUE_W-1:0] load_mag,
    output logic [3:0]         top_digit,
    output logic               ovf
);

    localparam int BCD_W = MAX_DIGITS * 4;

    logic [VALUE_W-1:0] bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic               ovf_reg;
    logic [BCD_W-1:0]   corr;

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int d = 0; d < MAX_DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] >= 4'd5)
                corr[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            else
                corr[d*4 +: 4] = bcd_reg[d*4 +: 4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            bin_reg <= load_mag;
            bcd_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (ctrl.shift_bit)
        begin
            bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= {corr[BCD_W-2:0], bin_reg[VALUE_W-1]};
            // a carry out of the top digit means leading digits are dropped
            ovf_reg <= ovf_reg | corr[BCD_W-1];
        end
        else if (ctrl.shift_digit)
        begin
            bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign ovf       = ovf_reg;

endmodule

[src/binary_to_decimal_ascii_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts one integer to its decimal ASCII text, one character per
// transaction, most significant digit first, with last on the final one.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  num     | in        | num_valid / num_stall | value, width_code, is_signed
//  chr     | out       | chr_valid / chr_stall | character, last
//
//  An item is loaded, shifted W bits (W = 8, 16, 32 or 64 from the width
//  code) through the bit-serial BCD register, given a minus sign if negative,
//  and then taken through MAX_DIGITS steps that either drop a leading zero or
//  emit a digit.
//  A new number is taken only once the previous one's last character has
//  entered the output register. Reset clears the sequencer and output valid.
//  A stalled output holds its character and freezes emission.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit
    import bda_pkg::*;
#(
    parameter int MAX_DIGITS = 20
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      num_valid,
    output logic      num_stall,
    input  num_item_t num,
    output logic      chr_valid,
    input  logic      chr_stall,
    output chr_item_t chr
);

    localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SIGN = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DCNT_W-1:0]    dig_cnt_reg, dig_cnt_next;
    logic                 neg_reg, neg_next;
    logic                 started_reg, started_next;
    logic                 out_valid_reg, out_valid_next;
    chr_item_t            out_data_reg, out_data_next;

    bda_ctrl_t            ctrl;
    logic [VALUE_W-1:0]   load_mag;
    logic [3:0]           top_digit;
    logic                 ovf;
    logic                 accept;
    logic                 out_free;
    logic                 sign_bit;
    logic                 neg_in;
    logic [VALUE_W-1:0]   mag_full;

    assign accept   = num_valid && !num_stall;
    assign out_free = !out_valid_reg || !chr_stall;

    always_comb
    begin
        case (num.width_code)
            WIDTH_8:  sign_bit = num.value[7];
            WIDTH_16: sign_bit = num.value[15];
            WIDTH_32: sign_bit = num.value[31];
            default:  sign_bit = num.value[63];
        endcase
        neg_in   = num.is_signed && sign_bit;
        mag_full = neg_in ? (~num.value + VALUE_W'(1)) : num.value;
        // left-align so the operand's top bit leaves first; upper bits fall off
        case (num.width_code)
            WIDTH_8:  load_mag = mag_full << 56;
            WIDTH_16: load_mag = mag_full << 48;
            WIDTH_32: load_mag = mag_full << 32;
            default:  load_mag = mag_full;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && chr_stall;
        out_data_next  = out_data_reg;
        ctrl           = '0;
        num_stall      = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                num_stall = 1'b0;
                if (num_valid)
                begin
                    ctrl.load    = 1'b1;
                    neg_next     = neg_in;
                    bit_cnt_next = BIT_CNT_W'(8) << num.width_code;
                    state_next   = S_CONV;
                end
            end
            S_CONV:
            begin
                ctrl.shift_bit = 1'b1;
                bit_cnt_next   = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    dig_cnt_next = DCNT_W'(MAX_DIGITS);
                    started_next = 1'b0;
                    state_next   = neg_reg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.character = CHAR_MINUS;
                    out_data_next.last      = 1'b0;
                    state_next              = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!started_reg && top_digit == 4'd0 &&
                    dig_cnt_reg != DCNT_W'(1) && !ovf)
                begin
                    // drop a leading zero
                    ctrl.shift_digit = 1'b1;
                    dig_cnt_next     = dig_cnt_reg - DCNT_W'(1);
                end
                else if (out_free)
                begin
                    ctrl.shift_digit        = 1'b1;
                    dig_cnt_next            = dig_cnt_reg - DCNT_W'(1);
                    started_next            = 1'b1;
                    out_valid_next          = 1'b1;
                    out_data_next.character = CHAR_ZERO + {4'd0, top_digit};
                    out_data_next.last      = (dig_cnt_reg == DCNT_W'(1));
                    if (dig_cnt_reg == DCNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            neg_reg       <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            neg_reg       <= neg_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    bda_dabble #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .clk       (clk),
        .ctrl      (ctrl),
        .load_mag  (load_mag),
        .top_digit (top_digit),
        .ovf       (ovf)
    );

    assign chr_valid = out_valid_reg;
    assign chr       = out_data_reg;

    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_CONV) && (bit_cnt_reg != '0))
        else $error("accepted transaction did not start conversion");

    a_sign_only_negative: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIGN) |-> neg_reg)
        else $error("minus sign stage entered for a non-negative value");

    a_emit_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (dig_cnt_reg != '0))
        else $error("digit count exhausted while emitting");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (chr_valid && chr.character == CHAR_MINUS) |-> !chr.last)
        else $error("minus sign flagged as final character");

endmodule
